// ----- src/msq_pkg.sv -----
package msq_pkg;

  localparam int ROW_W     = 10;
  localparam int SMP_W     = 32;
  localparam int FRAC_W    = 17;
  localparam int REL_W     = SMP_W + 1;
  localparam int MAG_W     = SMP_W + 1;
  localparam int DEN_W     = MAG_W + 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int Q_W       = 16;
  localparam int DIV_STEPS = 4;
  localparam int PROD_W    = 2 * MAG_W;

  localparam logic [FRAC_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [FRAC_W-1:0] HALF_Q16 = 17'd32768;
  localparam logic [3:0]        FOLD_LIMIT = 4'd7;

  // folded corner patterns
  localparam logic [2:0] CFG_NONE   = 3'd0;
  localparam logic [2:0] CFG_LB     = 3'd1;
  localparam logic [2:0] CFG_BR     = 3'd2;
  localparam logic [2:0] CFG_LR     = 3'd3;
  localparam logic [2:0] CFG_LT     = 3'd4;
  localparam logic [2:0] CFG_BT     = 3'd5;
  localparam logic [2:0] CFG_SADDLE = 3'd6;
  localparam logic [2:0] CFG_TR     = 3'd7;

  typedef enum logic [1:0] {
    EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP
  } msq_edge_id_t;

  typedef enum logic [1:0] {
    TSEL_DIV, TSEL_HALF, TSEL_ONE
  } msq_tsel_t;

  typedef struct packed {
    logic [ROW_W-1:0]        cell_row;
    logic [ROW_W-1:0]        cell_col;
    logic signed [SMP_W-1:0] corner_top_left;
    logic signed [SMP_W-1:0] corner_top_right;
    logic signed [SMP_W-1:0] corner_bottom_left;
    logic signed [SMP_W-1:0] corner_bottom_right;
  } msq_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  seg_cell_row;
    logic [ROW_W-1:0]  seg_cell_col;
    logic [FRAC_W-1:0] start_row_frac;
    logic [FRAC_W-1:0] start_col_frac;
    logic [FRAC_W-1:0] end_row_frac;
    logic [FRAC_W-1:0] end_col_frac;
    logic              last_segment;
  } msq_out_t;

  typedef struct packed {
    msq_tsel_t        tsel;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
  } msq_edge_t;

  typedef struct packed {
    logic             valid;
    logic             live;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [2:0]       cfg;
  } msq_meta_t;

  typedef struct packed {
    msq_edge_id_t e0;
    msq_edge_id_t e1;
  } msq_seg_t;

  function automatic msq_seg_t seg_edges(input logic [2:0] cfg, input logic pair1,
                                         input logic idx);
    msq_seg_t s;
    s.e0 = EDGE_LEFT;
    s.e1 = EDGE_BOTTOM;
    case (cfg)
      CFG_LB: begin s.e0 = EDGE_LEFT;   s.e1 = EDGE_BOTTOM; end
      CFG_BR: begin s.e0 = EDGE_BOTTOM; s.e1 = EDGE_RIGHT;  end
      CFG_LR: begin s.e0 = EDGE_LEFT;   s.e1 = EDGE_RIGHT;  end
      CFG_LT: begin s.e0 = EDGE_LEFT;   s.e1 = EDGE_TOP;    end
      CFG_BT: begin s.e0 = EDGE_BOTTOM; s.e1 = EDGE_TOP;    end
      CFG_TR: begin s.e0 = EDGE_TOP;    s.e1 = EDGE_RIGHT;  end
      CFG_SADDLE: begin
        if (pair1) begin
          s.e0 = idx ? EDGE_LEFT : EDGE_BOTTOM;
          s.e1 = idx ? EDGE_TOP  : EDGE_RIGHT;
        end else begin
          s.e0 = idx ? EDGE_RIGHT : EDGE_BOTTOM;
          s.e1 = idx ? EDGE_TOP   : EDGE_LEFT;
        end
      end
      default: begin s.e0 = EDGE_LEFT; s.e1 = EDGE_BOTTOM; end
    endcase
    return s;
  endfunction

endpackage

// ----- src/msq_front.sv -----
module msq_front #(
  parameter int GRID_DIM = 1024
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         take,
  input  msq_pkg::msq_in_t                             item,
  input  logic signed [msq_pkg::SMP_W-1:0]             level,
  output msq_pkg::msq_meta_t                           meta_o,
  output msq_pkg::msq_edge_t [3:0]                     edges_o,
  output logic [3:0][msq_pkg::MAG_W-1:0]               mags_o,
  output logic                                         bl_above_o
);
  import msq_pkg::*;

  localparam logic [16:0] LimC = 17'(GRID_DIM - 1);

  // stage A: values relative to the level, order tl, tr, bl, br
  logic signed [REL_W-1:0] rel_a_r [4];
  logic [ROW_W-1:0]        row_a_r, col_a_r;
  logic                    valid_a_r, inr_a_r;

  logic signed [REL_W-1:0] lvl_x;
  logic                    inr_nxt;

  assign lvl_x   = REL_W'(level);
  assign inr_nxt = ({7'd0, item.cell_row} < LimC) && ({7'd0, item.cell_col} < LimC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel_a_r[0] <= REL_W'(item.corner_top_left) - lvl_x;
      rel_a_r[1] <= REL_W'(item.corner_top_right) - lvl_x;
      rel_a_r[2] <= REL_W'(item.corner_bottom_left) - lvl_x;
      rel_a_r[3] <= REL_W'(item.corner_bottom_right) - lvl_x;
      row_a_r    <= item.cell_row;
      col_a_r    <= item.cell_col;
      inr_a_r    <= inr_nxt;
    end
  end

  // stage B: classification, magnitudes and divider setup
  function automatic logic [MAG_W-1:0] mag(input logic signed [REL_W-1:0] v);
    return v[REL_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic msq_edge_t edge_init(input logic signed [REL_W-1:0] a,
                                          input logic signed [REL_W-1:0] b);
    msq_edge_t        e;
    logic             crossed;
    logic [MAG_W-1:0] ma, mb;
    logic [DEN_W-1:0] den;
    ma      = mag(a);
    mb      = mag(b);
    den     = {1'b0, ma} + {1'b0, mb};
    crossed = (a <= 0 && b >= 0) || (a >= 0 && b <= 0);
    e.rem   = REM_W'(ma);
    e.den   = den;
    e.q     = '0;
    if (!crossed || (a == 0 && b == 0)) begin
      e.tsel = TSEL_HALF;
    end else if (b == 0) begin
      e.tsel = TSEL_ONE;
    end else begin
      e.tsel = TSEL_DIV;
    end
    return e;
  endfunction

  logic [3:0] raw;
  logic [2:0] fold;

  assign raw  = {~rel_a_r[1][REL_W-1], ~rel_a_r[0][REL_W-1],
                 ~rel_a_r[3][REL_W-1], ~rel_a_r[2][REL_W-1]};
  assign fold = (raw > FOLD_LIMIT) ? 3'(~raw) : raw[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_o.valid <= 1'b0;
    end else if (en) begin
      meta_o.valid <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_o.live <= inr_a_r && (fold != CFG_NONE);
      meta_o.row  <= row_a_r;
      meta_o.col  <= col_a_r;
      meta_o.cfg  <= fold;
      edges_o[EDGE_LEFT]   <= edge_init(rel_a_r[2], rel_a_r[0]);
      edges_o[EDGE_BOTTOM] <= edge_init(rel_a_r[2], rel_a_r[3]);
      edges_o[EDGE_RIGHT]  <= edge_init(rel_a_r[3], rel_a_r[1]);
      edges_o[EDGE_TOP]    <= edge_init(rel_a_r[0], rel_a_r[1]);
      for (int i = 0; i < 4; i++) begin
        mags_o[i] <= mag(rel_a_r[i]);
      end
      bl_above_o <= !rel_a_r[2][REL_W-1];
    end
  end

endmodule

// ----- src/msq_div_stage.sv -----
module msq_div_stage (
  input  logic                     clk,
  input  logic                     en,
  input  msq_pkg::msq_edge_t [3:0] edges_i,
  output msq_pkg::msq_edge_t [3:0] edges_o
);
  import msq_pkg::*;

  // restoring division, DIV_STEPS quotient bits per stage on every edge
  function automatic msq_edge_t steps(input msq_edge_t e);
    msq_edge_t        r;
    logic [REM_W-1:0] sh;
    r = e;
    for (int s = 0; s < DIV_STEPS; s++) begin
      sh = {r.rem[REM_W-2:0], 1'b0};
      if (sh >= {1'b0, r.den}) begin
        r.rem = sh - {1'b0, r.den};
        r.q   = {r.q[Q_W-2:0], 1'b1};
      end else begin
        r.rem = sh;
        r.q   = {r.q[Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        edges_o[i] <= steps(edges_i[i]);
      end
    end
  end

endmodule

// ----- src/msq_saddle.sv -----
module msq_saddle (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [3:0][msq_pkg::MAG_W-1:0]       mags_i,
  input  logic                                 bl_above,
  output logic                                 pair1_o
);
  import msq_pkg::*;

  // mags order: tl, tr, bl, br
  logic [PROD_W-1:0] p1_r, p2_r;
  logic              bl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= PROD_W'(mags_i[2]) * PROD_W'(mags_i[1]);
      p2_r <= PROD_W'(mags_i[3]) * PROD_W'(mags_i[0]);
      bl_r <= bl_above;
    end
  end

  // bottom-right/left-top pairing when the saddle sits on bottom-left's side
  always_ff @(posedge clk) begin
    if (en) begin
      pair1_o <= bl_r ? (p1_r >= p2_r) : (p1_r > p2_r);
    end
  end

endmodule

// ----- src/msq_emit.sv -----
module msq_emit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  msq_pkg::msq_meta_t       meta_i,
  input  msq_pkg::msq_edge_t [3:0] edges_i,
  input  logic                     pair1_i,
  output logic                     hold,
  output logic                     out_valid,
  output msq_pkg::msq_out_t        out_item
);
  import msq_pkg::*;

  logic              idx_r;
  logic [1:0]        nseg;
  logic [FRAC_W-1:0] t    [4];
  msq_seg_t          seg;

  assign nseg = (!meta_i.live) ? 2'd0 : (meta_i.cfg == CFG_SADDLE) ? 2'd2 : 2'd1;
  assign hold = meta_i.valid && (nseg == 2'd2) && !idx_r;
  assign seg  = seg_edges(meta_i.cfg, pair1_i, idx_r);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (edges_i[i].tsel)
        TSEL_HALF: t[i] = HALF_Q16;
        TSEL_ONE:  t[i] = ONE_Q16;
        default:   t[i] = FRAC_W'(edges_i[i].q);
      endcase
    end
  end

  function automatic logic [2*FRAC_W-1:0] point(input msq_edge_id_t e,
                                                input logic [FRAC_W-1:0] tv);
    logic [2*FRAC_W-1:0] p;
    case (e)
      EDGE_LEFT:   p = {ONE_Q16 - tv, {FRAC_W{1'b0}}};
      EDGE_BOTTOM: p = {ONE_Q16, tv};
      EDGE_RIGHT:  p = {ONE_Q16 - tv, ONE_Q16};
      default:     p = {{FRAC_W{1'b0}}, tv};
    endcase
    return p;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      idx_r     <= hold;
      out_valid <= meta_i.valid && (nseg != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    out_item.seg_cell_row <= meta_i.row;
    out_item.seg_cell_col <= meta_i.col;
    {out_item.start_row_frac, out_item.start_col_frac} <= point(seg.e0, t[seg.e0]);
    {out_item.end_row_frac, out_item.end_col_frac}     <= point(seg.e1, t[seg.e1]);
    out_item.last_segment <= (nseg == 2'd1) || idx_r;
  end

endmodule

// ----- src/marching_squares_cell_unit.sv -----
// channel | ports                         | handshake
// input   | start, busy, in_item          | taken when start && !busy
// result  | out_valid, out_item           | one-cycle strobe, no backpressure
// config  | cfg_valid, cfg_ready, cfg_data| written when cfg_valid && cfg_ready
//
// Cells pass stages A and B, the dividers and emit; one cell per cycle unless busy.
// A saddle cell emits two segments on consecutive cycles; busy is high in the
// cycle before the first of them and the whole pipeline holds for that cycle.
// Synchronous active-low reset clears valid bits and sets the level to 0.
module marching_squares_cell_unit #(
  parameter int GRID_DIM = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  msq_pkg::msq_in_t                 in_item,
  output logic                             out_valid,
  output msq_pkg::msq_out_t                out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic signed [msq_pkg::SMP_W-1:0] cfg_data
);
  import msq_pkg::*;

  logic signed [SMP_W-1:0] level_r;
  logic                    adv;

  msq_meta_t           meta_b, meta_c_r, meta_d_r, meta_e_r, meta_f_r;
  msq_edge_t [3:0]     edges_b, edges_c, edges_d, edges_e, edges_f;
  logic [3:0][MAG_W-1:0] mags_b;
  logic                bl_above_b;
  logic                pair1_d, pair1_e_r, pair1_f_r;

  assign adv       = !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      level_r <= cfg_data;
    end
  end

  msq_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .take       (start),
    .item       (in_item),
    .level      (level_r),
    .meta_o     (meta_b),
    .edges_o    (edges_b),
    .mags_o     (mags_b),
    .bl_above_o (bl_above_b)
  );

  msq_div_stage u_div0 (.clk(clk), .en(adv), .edges_i(edges_b), .edges_o(edges_c));
  msq_div_stage u_div1 (.clk(clk), .en(adv), .edges_i(edges_c), .edges_o(edges_d));
  msq_div_stage u_div2 (.clk(clk), .en(adv), .edges_i(edges_d), .edges_o(edges_e));
  msq_div_stage u_div3 (.clk(clk), .en(adv), .edges_i(edges_e), .edges_o(edges_f));

  msq_saddle u_saddle (
    .clk      (clk),
    .en       (adv),
    .mags_i   (mags_b),
    .bl_above (bl_above_b),
    .pair1_o  (pair1_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_c_r.valid <= 1'b0;
      meta_d_r.valid <= 1'b0;
      meta_e_r.valid <= 1'b0;
      meta_f_r.valid <= 1'b0;
    end else if (adv) begin
      meta_c_r.valid <= meta_b.valid;
      meta_d_r.valid <= meta_c_r.valid;
      meta_e_r.valid <= meta_d_r.valid;
      meta_f_r.valid <= meta_e_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {meta_c_r.live, meta_c_r.row, meta_c_r.col, meta_c_r.cfg} <=
        {meta_b.live, meta_b.row, meta_b.col, meta_b.cfg};
      {meta_d_r.live, meta_d_r.row, meta_d_r.col, meta_d_r.cfg} <=
        {meta_c_r.live, meta_c_r.row, meta_c_r.col, meta_c_r.cfg};
      {meta_e_r.live, meta_e_r.row, meta_e_r.col, meta_e_r.cfg} <=
        {meta_d_r.live, meta_d_r.row, meta_d_r.col, meta_d_r.cfg};
      {meta_f_r.live, meta_f_r.row, meta_f_r.col, meta_f_r.cfg} <=
        {meta_e_r.live, meta_e_r.row, meta_e_r.col, meta_e_r.cfg};
      pair1_e_r <= pair1_d;
      pair1_f_r <= pair1_e_r;
    end
  end

  msq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .meta_i    (meta_f_r),
    .edges_i   (edges_f),
    .pair1_i   (pair1_f_r),
    .hold      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- src/msq_checker.sv -----
module msq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input msq_pkg::msq_out_t out_item
);
  import msq_pkg::*;

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_busy_first_seg: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !out_item.last_segment))
    else $error("busy without a following first segment");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_segment) |=> (out_valid && out_item.last_segment))
    else $error("second segment missing");

  a_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_segment) |=>
      (out_item.seg_cell_row == $past(out_item.seg_cell_row) &&
       out_item.seg_cell_col == $past(out_item.seg_cell_col)))
    else $error("segment pair split across cells");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.start_row_frac <= ONE_Q16 && out_item.start_col_frac <= ONE_Q16 &&
                   out_item.end_row_frac <= ONE_Q16 && out_item.end_col_frac <= ONE_Q16))
    else $error("endpoint fraction out of range");

endmodule

bind marching_squares_cell_unit msq_checker u_msq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- dv/marching_squares_cell_unit_tb.sv -----
module marching_squares_cell_unit_tb;
  import msq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  msq_in_t in_item;
  logic out_valid;
  msq_out_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic signed [SMP_W-1:0] cfg_data;

  marching_squares_cell_unit #(.GRID_DIM(GRID)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // predictor state
  logic signed [SMP_W-1:0] level;
  msq_out_t seg_q[$];
  int errors;
  int idle_pct;
  int quiet_cycles;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic logic [FRAC_W-1:0] q16_div(input logic [63:0] num,
                                                input logic [63:0] den);
    logic [63:0] r;
    logic [FRAC_W-1:0] q;
    r = num;
    q = '0;
    if (den == 0) return HALF_Q16;
    if (num >= den) return ONE_Q16;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [FRAC_W-1:0] cross_frac(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic crossed;
    crossed = (a <= 0 && b >= 0) || (a >= 0 && b <= 0);
    if (!crossed || (a == 0 && b == 0)) return HALF_Q16;
    return q16_div(abs64(a), abs64(a) + abs64(b));
  endfunction

  // rel order: top-left, top-right, bottom-left, bottom-right
  task automatic edge_point(input msq_edge_id_t e, input logic signed [63:0] rel[4],
                            output logic [FRAC_W-1:0] r, output logic [FRAC_W-1:0] c);
    case (e)
      EDGE_LEFT: begin
        r = ONE_Q16 - cross_frac(rel[2], rel[0]); c = '0;
      end
      EDGE_BOTTOM: begin
        r = ONE_Q16; c = cross_frac(rel[2], rel[3]);
      end
      EDGE_RIGHT: begin
        r = ONE_Q16 - cross_frac(rel[3], rel[1]); c = ONE_Q16;
      end
      default: begin
        r = '0; c = cross_frac(rel[0], rel[1]);
      end
    endcase
  endtask

  task automatic push_segment(input msq_in_t it, input logic signed [63:0] rel[4],
                              input msq_edge_id_t e0, input msq_edge_id_t e1);
    msq_out_t s;
    s.seg_cell_row = it.cell_row;
    s.seg_cell_col = it.cell_col;
    edge_point(e0, rel, s.start_row_frac, s.start_col_frac);
    edge_point(e1, rel, s.end_row_frac, s.end_col_frac);
    s.last_segment = 1'b0;
    seg_q = {seg_q, s};
  endtask

  task automatic predict_cell(input msq_in_t it);
    logic signed [63:0] rel[4];
    logic [3:0] pat;
    logic [127:0] p1, p2;
    logic bl_above, s_above;
    int n0;
    n0 = seg_q.size();
    if (it.cell_row >= GRID - 1 || it.cell_col >= GRID - 1) return;
    rel[0] = 64'(it.corner_top_left) - 64'(level);
    rel[1] = 64'(it.corner_top_right) - 64'(level);
    rel[2] = 64'(it.corner_bottom_left) - 64'(level);
    rel[3] = 64'(it.corner_bottom_right) - 64'(level);
    pat = {rel[1] >= 0, rel[0] >= 0, rel[3] >= 0, rel[2] >= 0};
    if (pat > FOLD_LIMIT) pat = ~pat;
    case (pat[2:0])
      CFG_LB: push_segment(it, rel, EDGE_LEFT, EDGE_BOTTOM);
      CFG_BR: push_segment(it, rel, EDGE_BOTTOM, EDGE_RIGHT);
      CFG_LR: push_segment(it, rel, EDGE_LEFT, EDGE_RIGHT);
      CFG_LT: push_segment(it, rel, EDGE_LEFT, EDGE_TOP);
      CFG_BT: push_segment(it, rel, EDGE_BOTTOM, EDGE_TOP);
      CFG_TR: push_segment(it, rel, EDGE_TOP, EDGE_RIGHT);
      CFG_SADDLE: begin
        bl_above = rel[2] >= 0;
        p1 = 128'(abs64(rel[2])) * 128'(abs64(rel[1]));
        p2 = 128'(abs64(rel[3])) * 128'(abs64(rel[0]));
        s_above = bl_above ? (p1 >= p2) : (p1 <= p2);
        if (s_above == bl_above) begin
          push_segment(it, rel, EDGE_BOTTOM, EDGE_RIGHT);
          push_segment(it, rel, EDGE_LEFT, EDGE_TOP);
        end else begin
          push_segment(it, rel, EDGE_BOTTOM, EDGE_LEFT);
          push_segment(it, rel, EDGE_RIGHT, EDGE_TOP);
        end
      end
      default: ;
    endcase
    if (seg_q.size() > n0) seg_q[seg_q.size() - 1].last_segment = 1'b1;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid) begin
        if (seg_q.size() == 0) begin
          report("segment with none expected");
        end else begin
          msq_out_t e;
          e = seg_q.pop_front();
          if (out_item.seg_cell_row !== e.seg_cell_row) report("seg_cell_row");
          if (out_item.seg_cell_col !== e.seg_cell_col) report("seg_cell_col");
          if (out_item.start_row_frac !== e.start_row_frac) report("start_row_frac");
          if (out_item.start_col_frac !== e.start_col_frac) report("start_col_frac");
          if (out_item.end_row_frac !== e.end_row_frac) report("end_row_frac");
          if (out_item.end_col_frac !== e.end_col_frac) report("end_col_frac");
          if (out_item.last_segment !== e.last_segment) report("last_segment");
        end
      end
    end
  end

  // start stays high after a request until the next idle cycle or drain
  task automatic send_cell(input msq_in_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_cell(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (seg_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic signed [SMP_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    level = v;
  endtask

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return level + $signed($urandom_range(8)) - 4;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return level + $signed({{12{1'b0}}, 20'($urandom)}) - 32'sh80000;
    endcase
  endfunction

  function automatic msq_in_t rand_cell();
    msq_in_t it;
    it.cell_row = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(GRID - 2));
    it.cell_col = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(GRID - 2));
    it.corner_top_left = rand_sample();
    it.corner_top_right = rand_sample();
    it.corner_bottom_left = rand_sample();
    it.corner_bottom_right = rand_sample();
    return it;
  endfunction

  function automatic msq_in_t mk_cell(input int r, input int c,
                                      input logic signed [SMP_W-1:0] tl,
                                      input logic signed [SMP_W-1:0] tr,
                                      input logic signed [SMP_W-1:0] bl,
                                      input logic signed [SMP_W-1:0] br);
    msq_in_t it;
    it.cell_row = 10'(r);
    it.cell_col = 10'(c);
    it.corner_top_left = tl;
    it.corner_top_right = tr;
    it.corner_bottom_left = bl;
    it.corner_bottom_right = br;
    return it;
  endfunction

  task automatic test_patterns();
    logic signed [SMP_W-1:0] hi, lo;
    hi = 32'sh20000;
    lo = -32'sh10000;
    // all sixteen corner patterns, bit order tr tl br bl
    for (int p = 0; p < 16; p++)
      send_cell(mk_cell(p, p + 1, p[2] ? hi : lo, p[3] ? hi : lo,
                        p[0] ? hi : lo, p[1] ? hi : lo));
  endtask

  task automatic test_special_cases();
    // saddles both ways
    send_cell(mk_cell(3, 4, -32'sh10000, 32'sh30000, 32'sh30000, -32'sh10000));
    send_cell(mk_cell(3, 5, -32'sh30000, 32'sh10000, 32'sh10000, -32'sh30000));
    send_cell(mk_cell(3, 6, 32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000));
    // corners equal to the level, flat cell
    send_cell(mk_cell(5, 5, 0, 0, 0, -1));
    send_cell(mk_cell(5, 6, 0, 0, 0, 0));
    // extremes of samples and position, outside grid
    send_cell(mk_cell(0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    send_cell(mk_cell(GRID - 2, GRID - 2, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    send_cell(mk_cell(GRID - 1, 0, -1, 1, 1, -1));
    send_cell(mk_cell(0, GRID - 1, -1, 1, 1, -1));
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        // saddle around the level when flip is set, else top-left sits on the level
        msq_in_t it;
        logic flip;
        it = rand_cell();
        flip = 1'($urandom_range(1));
        it.corner_top_left = level + (flip ? -32'sh1 : 32'sh0) * $signed({1'b0, 15'($urandom)});
        it.corner_bottom_right = level - $signed({1'b0, 20'($urandom)}) - (flip ? 1 : 0);
        it.corner_top_right = level + $signed({1'b0, 20'($urandom)});
        it.corner_bottom_left = level + $signed({1'b0, 20'($urandom)});
        if (flip) begin
          it.corner_top_left = level - 1 - $signed({1'b0, 20'($urandom)});
        end
        send_cell(it);
      end else begin
        send_cell(rand_cell());
      end
    end
  endtask

  task automatic test_level_sweep();
    logic signed [SMP_W-1:0] levels[4];
    levels = '{32'sh7fffffff, 32'sh80000000, $urandom, 32'sh18000};
    foreach (levels[i]) begin
      write_level(levels[i]);
      test_random(60);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    level = '0;
    errors = 0;
    quiet_cycles = 0;
    idle_pct = 18;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_patterns();
    test_special_cases();
    test_random(160);
    test_level_sweep();
    idle_pct = 80;
    write_level(-32'sh8000);
    test_random(110);
    idle_pct = 0;
    write_level(32'sh0);
    test_random(150);
    drain();
    if (seg_q.size() != 0) report("expected segments never arrived");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- marching_squares_cell_unit.f -----
src/msq_pkg.sv
src/msq_front.sv
src/msq_div_stage.sv
src/msq_saddle.sv
src/msq_emit.sv
src/marching_squares_cell_unit.sv
src/msq_checker.sv
dv/marching_squares_cell_unit_tb.sv
